### src/sbc_pkg.sv
// sbc_pkg: shared types and constants for the sphere/box contact engine
// no dependencies; used by sbc_front, sbc_queue, sbc_back and the top level
package sbc_pkg;

    localparam int Axes       = 3;
    localparam int DvWidth    = 34;
    localparam int SqrtStages = 32;
    localparam int QuoBits    = 17;
    localparam logic [QuoBits-1:0] NormOne = 17'd65536;

    // classified item handed from the front to the back
    typedef struct packed {
        logic [Axes-1:0][31:0]        c;
        logic [30:0]                  r;
        logic [Axes-1:0][31:0]        pt;
        logic [Axes-1:0][DvWidth-1:0] dv;
        logic [Axes-1:0][30:0]        gap;
        logic                         gap_fail;
        logic                         in_box;
    } t_cls;

    // payload carried down the back pipeline
    typedef struct packed {
        logic [Axes-1:0][31:0] c;
        logic [30:0]           r;
        logic [Axes-1:0][31:0] pt;
        logic [Axes-1:0]       neg;
        logic [Axes-1:0][30:0] m;
        logic                  in_box;
        logic                  hit;
        logic                  zero;
    } t_work;

endpackage

### src/sbc_queue.sv
// sbc_queue: short register queue between front and back
// depends on sbc_pkg for the item type
module sbc_queue #(
    parameter int DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  sbc_pkg::t_cls i_item,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output sbc_pkg::t_cls o_item
);
    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    sbc_pkg::t_cls   r_mem [DEPTH];
    logic [PtrW-1:0] r_wp, r_rp;
    logic [CntW-1:0] r_cnt;

    assign o_full  = (r_cnt == CntW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PtrW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PtrW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + CntW'(i_push) - CntW'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end
endmodule

### src/sbc_front.sv
// sbc_front: input register and per-axis slab classification
// depends on sbc_pkg; feeds sbc_queue
module sbc_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  logic [31:0]   i_center_x,
    input  logic [31:0]   i_center_y,
    input  logic [31:0]   i_center_z,
    input  logic [30:0]   i_radius,
    input  logic [31:0]   i_box_min_x,
    input  logic [31:0]   i_box_min_y,
    input  logic [31:0]   i_box_min_z,
    input  logic [31:0]   i_box_max_x,
    input  logic [31:0]   i_box_max_y,
    input  logic [31:0]   i_box_max_z,
    output logic          o_push,
    output sbc_pkg::t_cls o_item,
    input  logic          i_full
);
    logic                            r_valid;
    logic [sbc_pkg::Axes-1:0][31:0]  r_c, r_lo, r_hi;
    logic [30:0]                     r_r;
    logic                            n_accept;

    assign o_stall  = r_valid && i_full;
    assign o_push   = r_valid && !i_full;
    assign n_accept = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (n_accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_accept) begin
            r_c  <= {i_center_z, i_center_y, i_center_x};
            r_lo <= {i_box_min_z, i_box_min_y, i_box_min_x};
            r_hi <= {i_box_max_z, i_box_max_y, i_box_max_x};
            r_r  <= i_radius;
        end
    end

    always_comb begin
        logic [sbc_pkg::Axes-1:0] below, above;
        logic signed [34:0]       cs, ls, hs, gap, dvv;
        o_item          = '0;
        o_item.c        = r_c;
        o_item.r        = r_r;
        o_item.gap_fail = 1'b0;
        for (int i = 0; i < sbc_pkg::Axes; i++) begin
            cs       = 35'(signed'(r_c[i]));
            ls       = 35'(signed'(r_lo[i]));
            hs       = 35'(signed'(r_hi[i]));
            below[i] = cs < ls;
            above[i] = !below[i] && (cs > hs);
            gap      = below[i] ? (ls - cs) : (above[i] ? (cs - hs) : 35'sd0);
            if (gap > 35'(r_r)) begin
                o_item.gap_fail = 1'b1;
            end
            o_item.gap[i] = gap[30:0];
            o_item.pt[i]  = below[i] ? r_lo[i] : (above[i] ? r_hi[i] : r_c[i]);
        end
        o_item.in_box = ~|(below | above);
        for (int i = 0; i < sbc_pkg::Axes; i++) begin
            cs = 35'(signed'(r_c[i]));
            ls = 35'(signed'(r_lo[i]));
            hs = 35'(signed'(r_hi[i]));
            if (o_item.in_box) begin
                dvv = (cs <<< 1) - (ls + hs);
            end else begin
                dvv = cs - 35'(signed'(o_item.pt[i]));
            end
            o_item.dv[i] = dvv[sbc_pkg::DvWidth-1:0];
        end
    end
endmodule

### src/sbc_back.sv
// sbc_back: pipelined hit test, normalization (square root, divide) and contact point
// depends on sbc_pkg; takes items from sbc_queue
module sbc_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_empty,
    input  sbc_pkg::t_cls i_item,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_stall,
    output logic          o_hit,
    output logic          o_center_inside,
    output logic [31:0]   o_contact_x,
    output logic [31:0]   o_contact_y,
    output logic [31:0]   o_contact_z,
    output logic [17:0]   o_normal_x,
    output logic [17:0]   o_normal_y,
    output logic [17:0]   o_normal_z
);
    localparam int A    = sbc_pkg::Axes;
    localparam int SQ   = sbc_pkg::SqrtStages;
    localparam int QB   = sbc_pkg::QuoBits;
    localparam int DW   = sbc_pkg::DvWidth;
    localparam int NST  = 4 + SQ + 1 + QB + 2;
    localparam int SQ0  = 3;
    localparam int DV0  = SQ0 + SQ + 1;
    localparam int MULI = DV0 + QB + 1;
    localparam int OUTI = MULI + 1;

    logic [NST-1:0] r_vld;
    logic           n_en;

    assign n_en    = !r_vld[OUTI] || !i_stall;
    assign o_pop   = n_en && !i_empty;
    assign o_valid = r_vld[OUTI];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (n_en) begin
            r_vld <= {r_vld[NST-2:0], !i_empty};
        end
    end

    // stage 1: squares of gaps, squared radius, magnitudes
    sbc_pkg::t_cls          r1_cls;
    logic [A-1:0][61:0]     r1_sq;
    logic [61:0]            r1_rr;
    logic [A-1:0][DW-1:0]   r1_mag;
    logic [A-1:0]           r1_neg;

    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r1_cls <= i_item;
            r1_rr  <= 62'(i_item.r) * 62'(i_item.r);
            for (int i = 0; i < A; i++) begin
                r1_sq[i]  <= 62'(i_item.gap[i]) * 62'(i_item.gap[i]);
                r1_neg[i] <= i_item.dv[i][DW-1];
                r1_mag[i] <= i_item.dv[i][DW-1] ? (~i_item.dv[i] + 1'b1) : i_item.dv[i];
            end
        end
    end

    // stage 2: hit decision, common power-of-two scaling
    sbc_pkg::t_work r2_w;
    always_ff @(posedge i_clk) begin
        logic [63:0]   sum;
        logic [DW-1:0] big;
        logic [5:0]    p;
        logic [63:0]   ext;
        if (n_en) begin
            sum = 64'(r1_sq[0]) + 64'(r1_sq[1]) + 64'(r1_sq[2]);
            big = r1_mag[0];
            for (int i = 1; i < A; i++) begin
                if (r1_mag[i] > big) begin
                    big = r1_mag[i];
                end
            end
            p = '0;
            for (int b = 0; b < DW; b++) begin
                if (big[b]) begin
                    p = 6'(b);
                end
            end
            r2_w.c      <= r1_cls.c;
            r2_w.r      <= r1_cls.r;
            r2_w.pt     <= r1_cls.pt;
            r2_w.neg    <= r1_neg;
            r2_w.in_box <= r1_cls.in_box;
            r2_w.hit    <= !r1_cls.gap_fail && (r1_cls.in_box || sum <= 64'(r1_rr));
            r2_w.zero   <= (big == '0);
            for (int i = 0; i < A; i++) begin
                ext = 64'(r1_mag[i]);
                if (p < 6'd30) begin
                    ext = ext << (6'd30 - p);
                end else begin
                    ext = ext >> (p - 6'd30);
                end
                r2_w.m[i] <= ext[30:0];
            end
        end
    end

    // stage 3: squares of scaled magnitudes
    sbc_pkg::t_work     r3_w;
    logic [A-1:0][61:0] r3_msq;
    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r3_w <= r2_w;
            for (int i = 0; i < A; i++) begin
                r3_msq[i] <= 62'(r2_w.m[i]) * 62'(r2_w.m[i]);
            end
        end
    end

    // square root: one result bit per stage
    logic [63:0]    r_sq_n   [SQ+1];
    logic [63:0]    r_sq_res [SQ+1];
    sbc_pkg::t_work r_sq_w   [SQ+1];

    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_sq_n[0]   <= 64'(r3_msq[0]) + 64'(r3_msq[1]) + 64'(r3_msq[2]);
            r_sq_res[0] <= '0;
            r_sq_w[0]   <= r3_w;
        end
    end

    for (genvar k = 0; k < SQ; k++) begin : g_sqrt
        localparam logic [63:0] Bit = 64'(1) << (62 - 2 * k);
        always_ff @(posedge i_clk) begin
            logic [63:0] t;
            if (n_en) begin
                t = r_sq_res[k] + Bit;
                if (r_sq_n[k] >= t) begin
                    r_sq_n[k+1]   <= r_sq_n[k] - t;
                    r_sq_res[k+1] <= (r_sq_res[k] >> 1) + Bit;
                end else begin
                    r_sq_n[k+1]   <= r_sq_n[k];
                    r_sq_res[k+1] <= r_sq_res[k] >> 1;
                end
                r_sq_w[k+1] <= r_sq_w[k];
            end
        end
    end

    // rounded division m * 2^16 / root, three lanes, one quotient bit per stage
    logic [A-1:0][48:0]   r_dv_rem  [QB+1];
    logic [A-1:0][QB-1:0] r_dv_q    [QB+1];
    logic [31:0]          r_dv_root [QB+1];
    sbc_pkg::t_work       r_dv_w    [QB+1];

    always_ff @(posedge i_clk) begin
        logic [31:0] root;
        if (n_en) begin
            root = r_sq_res[SQ][31:0];
            r_dv_root[0] <= root;
            r_dv_w[0]    <= r_sq_w[SQ];
            for (int i = 0; i < A; i++) begin
                r_dv_rem[0][i] <= {r_sq_w[SQ].m[i], 16'd0} + 49'(root >> 1);
                r_dv_q[0][i]   <= '0;
            end
        end
    end

    for (genvar j = 0; j < QB; j++) begin : g_div
        localparam int Sh = QB - 1 - j;
        always_ff @(posedge i_clk) begin
            logic [48:0]   d;
            logic [QB-1:0] q;
            if (n_en) begin
                d = 49'(r_dv_root[j]) << Sh;
                for (int i = 0; i < A; i++) begin
                    q = r_dv_q[j][i];
                    if (r_dv_rem[j][i] >= d) begin
                        r_dv_rem[j+1][i] <= r_dv_rem[j][i] - d;
                        q[Sh] = 1'b1;
                    end else begin
                        r_dv_rem[j+1][i] <= r_dv_rem[j][i];
                    end
                    r_dv_q[j+1][i] <= q;
                end
                r_dv_root[j+1] <= r_dv_root[j];
                r_dv_w[j+1]    <= r_dv_w[j];
            end
        end
    end

    // radius times normal magnitude, rounded
    sbc_pkg::t_work       r_mu_w;
    logic [A-1:0][QB-1:0] r_mu_q;
    logic [A-1:0][32:0]   r_mu_off;
    always_ff @(posedge i_clk) begin
        logic [QB-1:0] q;
        logic [47:0]   prod;
        if (n_en) begin
            r_mu_w <= r_dv_w[QB];
            for (int i = 0; i < A; i++) begin
                q = r_dv_w[QB].zero ? '0 : r_dv_q[QB][i];
                if (q > sbc_pkg::NormOne) begin
                    q = sbc_pkg::NormOne;
                end
                prod = 48'(r_dv_w[QB].r) * 48'(q) + 48'h8000;
                r_mu_q[i]   <= q;
                r_mu_off[i] <= 33'(prod[47:16]);
            end
        end
    end

    // output register: saturated point and signed normal
    always_ff @(posedge i_clk) begin
        logic signed [34:0] s;
        logic [31:0]        pt [A];
        logic [17:0]        nv [A];
        if (n_en) begin
            for (int i = 0; i < A; i++) begin
                if (r_mu_w.in_box) begin
                    s = r_mu_w.neg[i] ? 35'(signed'(r_mu_w.c[i])) - 35'(r_mu_off[i])
                                      : 35'(signed'(r_mu_w.c[i])) + 35'(r_mu_off[i]);
                    if (s > 35'sd2147483647) begin
                        pt[i] = 32'h7fff_ffff;
                    end else if (s < -35'sd2147483648) begin
                        pt[i] = 32'h8000_0000;
                    end else begin
                        pt[i] = s[31:0];
                    end
                end else begin
                    pt[i] = r_mu_w.pt[i];
                end
                nv[i] = r_mu_w.neg[i] ? (18'd0 - 18'(r_mu_q[i])) : 18'(r_mu_q[i]);
                if (!r_mu_w.hit) begin
                    pt[i] = '0;
                    nv[i] = '0;
                end
            end
            o_hit           <= r_mu_w.hit;
            o_center_inside <= r_mu_w.hit && r_mu_w.in_box;
            o_contact_x     <= pt[0];
            o_contact_y     <= pt[1];
            o_contact_z     <= pt[2];
            o_normal_x      <= nv[0];
            o_normal_y      <= nv[1];
            o_normal_z      <= nv[2];
        end
    end
endmodule

### src/sphere_box_contact.sv
// Sphere against axis-aligned box contact engine. Each transfer on the input channel
// carries one sphere (Q16.16 centre, radius) and one box (min and max corners); each
// transfer on the output channel returns hit, center_inside, the contact point and
// the unit normal, one result per item, in order. The block takes one item per cycle
// when the output side does not stall. On its way from input transfer to result valid
// an item passes the front register, the queue and then the back stages set by the
// 32-stage bit-per-stage square root and the 17-stage dividers that normalize the
// contact normal. The front registers and classifies items and pushes them into a
// QUEUE_DEPTH-entry queue; the back pipeline moves as one when its output register
// is free or being taken. A miss still returns one result, with point and normal all
// zero.
// depends on sbc_pkg, sbc_front, sbc_queue, sbc_back
module sphere_box_contact #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_center_x,
    input  logic [31:0] i_center_y,
    input  logic [31:0] i_center_z,
    input  logic [30:0] i_radius,
    input  logic [31:0] i_box_min_x,
    input  logic [31:0] i_box_min_y,
    input  logic [31:0] i_box_min_z,
    input  logic [31:0] i_box_max_x,
    input  logic [31:0] i_box_max_y,
    input  logic [31:0] i_box_max_z,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_hit,
    output logic        o_center_inside,
    output logic [31:0] o_contact_x,
    output logic [31:0] o_contact_y,
    output logic [31:0] o_contact_z,
    output logic [17:0] o_normal_x,
    output logic [17:0] o_normal_y,
    output logic [17:0] o_normal_z
);
    sbc_pkg::t_cls w_push_item, w_head_item;
    logic          w_push, w_full, w_pop, w_empty;

    // front: input register and slab classification
    sbc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .o_stall     (o_in_stall),
        .i_center_x  (i_center_x),
        .i_center_y  (i_center_y),
        .i_center_z  (i_center_z),
        .i_radius    (i_radius),
        .i_box_min_x (i_box_min_x),
        .i_box_min_y (i_box_min_y),
        .i_box_min_z (i_box_min_z),
        .i_box_max_x (i_box_max_x),
        .i_box_max_y (i_box_max_y),
        .i_box_max_z (i_box_max_z),
        .o_push      (w_push),
        .o_item      (w_push_item),
        .i_full      (w_full)
    );

    // decoupling queue between front and back
    sbc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_item  (w_head_item)
    );

    // back: hit test, normalization, contact point, output register
    sbc_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_empty         (w_empty),
        .i_item          (w_head_item),
        .o_pop           (w_pop),
        .o_valid         (o_out_valid),
        .i_stall         (i_out_stall),
        .o_hit           (o_hit),
        .o_center_inside (o_center_inside),
        .o_contact_x     (o_contact_x),
        .o_contact_y     (o_contact_y),
        .o_contact_z     (o_contact_z),
        .o_normal_x      (o_normal_x),
        .o_normal_y      (o_normal_y),
        .o_normal_z      (o_normal_z)
    );

    // a miss carries an all-zero point and normal
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_hit) |-> (o_contact_x == '0 && o_contact_y == '0 &&
            o_contact_z == '0 && o_normal_x == '0 && o_normal_y == '0 &&
            o_normal_z == '0))
        else $error("miss with nonzero payload");

    // inside only with a hit
    a_inside_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_center_inside) |-> o_hit)
        else $error("center_inside without hit");

    // normal components stay within unit range
    a_norm_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ($signed(o_normal_x) <= 18'sd65536 &&
            $signed(o_normal_x) >= -18'sd65536 &&
            $signed(o_normal_y) <= 18'sd65536 && $signed(o_normal_y) >= -18'sd65536 &&
            $signed(o_normal_z) <= 18'sd65536 && $signed(o_normal_z) >= -18'sd65536))
        else $error("normal out of range");

    // queue never pushed while full
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_full |-> !w_push)
        else $error("queue overflow");
endmodule

### tb/sv/tb_sphere_box_contact.sv
// testbench for sphere_box_contact: directed and random sphere/box pairs
// checked against a behavioral contact predictor; depends on the RTL top only
`timescale 1ns / 100ps

module tb_sphere_box_contact;

    typedef struct {
        logic [31:0] c [3];
        logic [30:0] r;
        logic [31:0] lo [3];
        logic [31:0] hi [3];
    } t_pair;

    typedef struct {
        logic        hit;
        logic        in_box;
        logic [31:0] pt [3];
        logic [17:0] nrm [3];
    } t_contact;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [31:0] i_center_x, i_center_y, i_center_z;
    logic [30:0] i_radius;
    logic [31:0] i_box_min_x, i_box_min_y, i_box_min_z;
    logic [31:0] i_box_max_x, i_box_max_y, i_box_max_z;
    logic        o_out_valid;
    logic        i_out_stall;
    logic        o_hit, o_center_inside;
    logic [31:0] o_contact_x, o_contact_y, o_contact_z;
    logic [17:0] o_normal_x, o_normal_y, o_normal_z;

    sphere_box_contact DUT (.*);

    t_pair    pending_pairs [$];
    t_contact expected_contacts [$];
    int       mismatch_count = 0;
    int       send_idle_pct = 0;
    int       recv_stall_pct = 0;
    int       recv_hold_cycles = 0;
    int       quiet_cycles = 0;
    bit       stim_done = 0;

    localparam int QuietLimit = 4000;

    // ---------------- predictor ----------------

    function automatic longint unsigned root_floor(longint unsigned n);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    // unit vector in Q16.16 with one common power-of-two prescale
    function automatic void unit_vector(input longint v [3], output longint n [3]);
        longint unsigned m [3];
        longint unsigned big, total, s, q;
        big = 0;
        total = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] = v[i] < 0 ? -v[i] : v[i];
            if (m[i] > big) big = m[i];
        end
        if (big == 0) begin
            for (int i = 0; i < 3; i++) n[i] = 0;
            return;
        end
        while (big < (64'd1 << 30)) begin
            big <<= 1;
            for (int i = 0; i < 3; i++) m[i] <<= 1;
        end
        while (big >= (64'd1 << 31)) begin
            big >>= 1;
            for (int i = 0; i < 3; i++) m[i] >>= 1;
        end
        for (int i = 0; i < 3; i++) total += m[i] * m[i];
        s = root_floor(total);
        for (int i = 0; i < 3; i++) begin
            q = ((m[i] << 16) + (s >> 1)) / s;
            if (q > 65536) q = 65536;
            n[i] = v[i] < 0 ? -longint'(q) : longint'(q);
        end
    endfunction

    function automatic t_contact predict_contact(t_pair p);
        t_contact res;
        longint c [3], lo [3], hi [3], pt [3], dv [3], nv [3];
        longint r, g, off, sum;
        longint unsigned dist_sq, mag;
        bit in_box, hit;
        r = p.r;
        dist_sq = 0;
        in_box = 1;
        hit = 1;
        for (int i = 0; i < 3; i++) begin
            c[i] = longint'(signed'(p.c[i]));
            lo[i] = longint'(signed'(p.lo[i]));
            hi[i] = longint'(signed'(p.hi[i]));
            g = 0;
            if (c[i] < lo[i]) begin
                g = lo[i] - c[i]; pt[i] = lo[i]; in_box = 0;
            end else if (c[i] > hi[i]) begin
                g = c[i] - hi[i]; pt[i] = hi[i]; in_box = 0;
            end else begin
                pt[i] = c[i];
            end
            if (g > r) hit = 0;
            else dist_sq += g * g;
        end
        if (hit && !in_box && dist_sq > longint'(r) * longint'(r)) hit = 0;
        res.hit = hit;
        res.in_box = hit && in_box;
        for (int i = 0; i < 3; i++) begin
            res.pt[i] = '0;
            res.nrm[i] = '0;
        end
        if (!hit) return res;
        if (in_box) begin
            for (int i = 0; i < 3; i++) dv[i] = 2 * c[i] - (lo[i] + hi[i]);
            unit_vector(dv, nv);
            for (int i = 0; i < 3; i++) begin
                mag = nv[i] < 0 ? -nv[i] : nv[i];
                off = (longint'(r) * mag + 64'h8000) >>> 16;
                sum = c[i] + (nv[i] < 0 ? -off : off);
                if (sum > 64'sd2147483647) sum = 64'sd2147483647;
                if (sum < -64'sd2147483648) sum = -64'sd2147483648;
                pt[i] = sum;
            end
        end else begin
            for (int i = 0; i < 3; i++) dv[i] = c[i] - pt[i];
            unit_vector(dv, nv);
        end
        for (int i = 0; i < 3; i++) begin
            res.pt[i] = pt[i][31:0];
            res.nrm[i] = nv[i][17:0];
        end
        return res;
    endfunction

    // ---------------- stimulus helpers ----------------

    function automatic logic [31:0] rand_coord(int mode);
        case (mode)
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 32'h40000)) - 32'sh20000);
            default: return 32'($signed($urandom_range(0, 32'h4000000)) - 32'sh2000000);
        endcase
    endfunction

    function automatic t_pair make_pair(logic [31:0] cx, logic [31:0] cy,
                                        logic [31:0] cz, logic [30:0] r,
                                        logic [31:0] lx, logic [31:0] ly,
                                        logic [31:0] lz, logic [31:0] hx,
                                        logic [31:0] hy, logic [31:0] hz);
        t_pair p;
        p.c[0] = cx; p.c[1] = cy; p.c[2] = cz; p.r = r;
        p.lo[0] = lx; p.lo[1] = ly; p.lo[2] = lz;
        p.hi[0] = hx; p.hi[1] = hy; p.hi[2] = hz;
        return p;
    endfunction

    // mostly ordered boxes near the sphere so hits and near misses are common
    function automatic t_pair rand_pair();
        t_pair p;
        int mode, sel;
        logic [31:0] a, b, t;
        mode = $urandom_range(0, 4);
        sel = $urandom_range(0, 9);
        for (int i = 0; i < 3; i++) begin
            a = rand_coord(mode);
            b = rand_coord(mode);
            if (sel != 0 && $signed(a) > $signed(b)) begin
                t = a; a = b; b = t;
            end
            p.lo[i] = a;
            p.hi[i] = b;
            case ($urandom_range(0, 3))
                0: p.c[i] = rand_coord(mode);
                1: p.c[i] = a - 32'($urandom_range(0, 32'h30000));
                2: p.c[i] = b + 32'($urandom_range(0, 32'h30000));
                default: p.c[i] = a + ((b - a) >> 1) + 32'($urandom_range(0, 3));
            endcase
        end
        case ($urandom_range(0, 3))
            0: p.r = 31'($urandom);
            1: p.r = 31'($urandom_range(0, 32'h60000));
            2: p.r = 31'($urandom_range(0, 32'h4000000));
            default: p.r = 31'($urandom_range(0, 255));
        endcase
        return p;
    endfunction

    // ---------------- clock, reset, stimulus ----------------

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    task automatic wait_drained();
        while (pending_pairs.size() != 0 || expected_contacts.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic run_phase(int n, int idle_pct, int stall_pct);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int k = 0; k < n; k++) pending_pairs.push_back(rand_pair());
        while (pending_pairs.size() != 0) @(posedge i_clk);
    endtask

    localparam logic [31:0] MaxPos = 32'h7fffffff;
    localparam logic [31:0] MinNeg = 32'h80000000;
    localparam logic [31:0] One = 32'h00010000;

    initial begin
        i_rst_n = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: extremes, touching, inside, zero normal, inverted box
        pending_pairs.push_back(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_pairs.push_back(make_pair(0, 0, 0, 31'h7fffffff, MinNeg, MinNeg, MinNeg,
                                          MaxPos, MaxPos, MaxPos));
        pending_pairs.push_back(make_pair(MaxPos, MaxPos, MaxPos, 31'h7fffffff,
                                          MinNeg, MinNeg, MinNeg, MinNeg, MinNeg, MinNeg));
        pending_pairs.push_back(make_pair(MinNeg, MinNeg, MinNeg, 31'h7fffffff,
                                          MaxPos, MaxPos, MaxPos, MaxPos, MaxPos, MaxPos));
        // touching exactly along one axis, then just out
        pending_pairs.push_back(make_pair(0, 0, 0, 31'h10000, One, 0, 0, 2 * One, One, One));
        pending_pairs.push_back(make_pair(0, 0, 0, 31'hffff, One, 0, 0, 2 * One, One, One));
        // touching on a corner: 3-4 triangle, radius 5
        pending_pairs.push_back(make_pair(0, 0, 0, 31'h50000, 3 * One, 4 * One, 0,
                                          5 * One, 5 * One, One));
        pending_pairs.push_back(make_pair(0, 0, 0, 31'h4ffff, 3 * One, 4 * One, 0,
                                          5 * One, 5 * One, One));
        // centre inside, off-centre and exactly at box centre
        pending_pairs.push_back(make_pair(One, 0, 0, 31'h20000, -2 * One, -One, -One,
                                          2 * One, One, One));
        pending_pairs.push_back(make_pair(0, 0, 0, 31'h20000, -One, -One, -One,
                                          One, One, One));
        // inside near the positive limit with a huge radius: saturation
        pending_pairs.push_back(make_pair(MaxPos - 5, 0, 0, 31'h7fffffff, 0, -One, -One,
                                          MaxPos, One, One));
        pending_pairs.push_back(make_pair(MinNeg + 5, 0, 0, 31'h7fffffff, MinNeg, -One, -One,
                                          0, One, One));
        // inverted box, below and above
        pending_pairs.push_back(make_pair(0, 0, 0, 31'h40000, One, -One, -One,
                                          -One, One, One));
        pending_pairs.push_back(make_pair(3 * One, 0, 0, 31'h40000, 2 * One, -One, -One,
                                          One, One, One));
        // gap above radius on a single axis, negative side
        pending_pairs.push_back(make_pair(0, 0, -10 * One, 31'h10000, -One, -One, -One,
                                          One, One, One));
        pending_pairs.push_back(make_pair(32'hffffffff, 32'h1, 32'hfffffffe, 31'h7fffffff,
                                          0, 0, 0, 0, 0, 0));
        send_idle_pct = 0;
        recv_stall_pct = 0;
        wait_drained();

        run_phase(50, 0, 0);
        run_phase(90, 61, 0);
        run_phase(90, 0, 61);

        // long receiver hold-off while items keep coming, input must back up
        recv_hold_cycles = 300;
        run_phase(100, 0, 0);
        wait_drained();
        // sender pauses here until every result is back
        run_phase(90, 61, 61);
        run_phase(30, 14, 14);
        wait_drained();
        repeat (80) @(posedge i_clk);
        stim_done = 1;
    end

    // ---------------- driver ----------------

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || !o_in_stall) begin
            // previous transfer taken (or none offered): consider a new one
            if (i_in_valid) begin
                expected_contacts.push_back(predict_contact(pending_pairs.pop_front()));
            end
            if (pending_pairs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                i_in_valid <= 1'b1;
                i_center_x <= pending_pairs[0].c[0];
                i_center_y <= pending_pairs[0].c[1];
                i_center_z <= pending_pairs[0].c[2];
                i_radius <= pending_pairs[0].r;
                i_box_min_x <= pending_pairs[0].lo[0];
                i_box_min_y <= pending_pairs[0].lo[1];
                i_box_min_z <= pending_pairs[0].lo[2];
                i_box_max_x <= pending_pairs[0].hi[0];
                i_box_max_y <= pending_pairs[0].hi[1];
                i_box_max_z <= pending_pairs[0].hi[2];
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    initial begin
        i_in_valid = 0;
        i_center_x = 0; i_center_y = 0; i_center_z = 0; i_radius = 0;
        i_box_min_x = 0; i_box_min_y = 0; i_box_min_z = 0;
        i_box_max_x = 0; i_box_max_y = 0; i_box_max_z = 0;
        i_out_stall = 0;
    end

    // ---------------- receiver stall ----------------

    always @(posedge i_clk) begin
        if (recv_hold_cycles > 0) begin
            recv_hold_cycles <= recv_hold_cycles - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // ---------------- monitor ----------------

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        t_contact want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_contacts.size() == 0) begin
                report_mismatch("unexpected result", 32'(o_hit), 0);
            end else begin
                want = expected_contacts.pop_front();
                if (o_hit !== want.hit) report_mismatch("hit", 32'(o_hit), 32'(want.hit));
                if (o_center_inside !== want.in_box)
                    report_mismatch("center_inside", 32'(o_center_inside), 32'(want.in_box));
                if (o_contact_x !== want.pt[0]) report_mismatch("contact_x", o_contact_x, want.pt[0]);
                if (o_contact_y !== want.pt[1]) report_mismatch("contact_y", o_contact_y, want.pt[1]);
                if (o_contact_z !== want.pt[2]) report_mismatch("contact_z", o_contact_z, want.pt[2]);
                if (o_normal_x !== want.nrm[0])
                    report_mismatch("normal_x", 32'(o_normal_x), 32'(want.nrm[0]));
                if (o_normal_y !== want.nrm[1])
                    report_mismatch("normal_y", 32'(o_normal_y), 32'(want.nrm[1]));
                if (o_normal_z !== want.nrm[2])
                    report_mismatch("normal_z", 32'(o_normal_z), 32'(want.nrm[2]));
            end
        end
    end

    // ---------------- watchdog and end of run ----------------

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (stim_done) begin
            if (mismatch_count == 0 && expected_contacts.size() == 0)
                $display("end of test: clean");
            else
                $display("end of test: mismatches");
            $finish;
        end else if (quiet_cycles >= QuietLimit) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

endmodule

### filelist.f
src/sbc_pkg.sv
src/sbc_queue.sv
src/sbc_front.sv
src/sbc_back.sv
src/sphere_box_contact.sv
tb/sv/tb_sphere_box_contact.sv
